@@ src/ffca_pkg.sv @@
// Shared types and constants for the first-fit coalescing allocator.
// No dependencies.
`default_nettype none

package ffca_pkg;

  localparam int unsigned ADDR_W = 23;
  localparam int unsigned SIZE_W = 24;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FIT      = 3'd1,
    ST_NOT_ALLOC   = 3'd2,
    ST_NULL_FREE   = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_FIT,
    S_SLOT,
    S_LOOK,
    S_WALK,
    S_MERGE,
    S_MV_RD,
    S_MV_WR,
    S_DONE
  } state_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] payload;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] min_free;
  } res_t;

endpackage

`default_nettype wire

@@ src/ffca_engine.sv @@
// Allocator sequencer: free segment memory, allocation memory and the walk logic.
// Depends on ffca_pkg.
`default_nettype none

module ffca_engine #(
  parameter int unsigned HEAP_BYTES      = 8388608,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned MAX_ALLOCATIONS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            op_i,
  input  wire logic [ffca_pkg::SIZE_W-1:0]     req_i,
  input  wire logic [ffca_pkg::ADDR_W-1:0]     addr_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output ffca_pkg::res_t                       res_o
);

  localparam int unsigned DEPTH = MAX_ALLOCATIONS + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned FIW   = $clog2(DEPTH);
  localparam int unsigned AIW   = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam int unsigned LW    = $clog2(MAX_ALLOCATIONS + 1);
  localparam int unsigned AW    = ffca_pkg::ADDR_W;
  localparam int unsigned SW    = ffca_pkg::SIZE_W;
  localparam logic [SW-1:0] INIT_SIZE = SW'((HEAP_BYTES - HEADER_BYTES) / 8 * 8);
  localparam logic [SW-1:0] HDR       = SW'(HEADER_BYTES);

  ffca_pkg::seg_t fmem [DEPTH];
  ffca_pkg::seg_t amem [MAX_ALLOCATIONS];
  ffca_pkg::seg_t f_rdata_q, a_rdata_q, f_wdata, a_wdata;
  logic [FIW-1:0] f_raddr, f_waddr;
  logic [AIW-1:0] a_raddr, a_waddr;
  logic           f_we, a_we;

  ffca_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]   live_q, live_d;
  logic [SW-1:0]   total_q, total_d, low_q, low_d;
  logic [MAX_ALLOCATIONS-1:0] valid_q, valid_d;

  logic            op_q, op_d;
  logic [SW-1:0]   req_q, req_d, need_q, need_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [CW-1:0]   k_q, k_d, m_q, m_d, i_q, i_d;
  logic            mv_up_q, mv_up_d;
  logic [AIW-1:0]  j_q, j_d, s_q, s_d;
  ffca_pkg::seg_t  seg_q, seg_d, prev_q, prev_d, next_q, next_d;
  logic            has_prev_q, has_prev_d, has_next_q, has_next_d;
  ffca_pkg::status_e status_q, status_d;
  logic [AW-1:0]   payload_q, payload_d;

  logic [SW:0]     need_w;
  logic            fit_hit, fit_last, look_hit, walk_less, walk_last;
  logic            join_prev, join_next;
  logic [SW-1:0]   rest_w, tot_sub;

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    f_rdata_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    a_rdata_q <= amem[a_raddr];
  end

  always_comb begin
    need_w    = ({1'b0, req_q} + {1'b0, HDR} + (SW+1)'(7)) & ~((SW+1)'(7));
    rest_w    = f_rdata_q.size - need_q;
    fit_hit   = f_rdata_q.size >= need_q;
    fit_last  = (k_q + CW'(1)) == cnt_q;
    look_hit  = valid_q[j_q] &&
                (({1'b0, a_rdata_q.start} + HDR) == {1'b0, addr_q});
    walk_less = f_rdata_q.start < seg_q.start;
    walk_last = (k_q + CW'(1)) == cnt_q;
    join_prev = has_prev_q &&
                (({1'b0, prev_q.start} + {1'b0, prev_q.size}) == {2'b0, seg_q.start});
    join_next = has_next_q &&
                (({1'b0, seg_q.start} + {1'b0, seg_q.size}) == {2'b0, next_q.start});
    tot_sub   = total_q - need_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffca_pkg::S_INIT: state_d = ffca_pkg::S_IDLE;
      ffca_pkg::S_IDLE: if (in_valid_i) state_d = ffca_pkg::S_CHECK;
      ffca_pkg::S_CHECK: begin
        if (op_q == ffca_pkg::OP_ALLOC) begin
          if (req_q == '0 || need_w > {1'b0, total_q} || cnt_q == '0) begin
            state_d = ffca_pkg::S_DONE;
          end else if (live_q == LW'(MAX_ALLOCATIONS)) begin
            state_d = ffca_pkg::S_DONE;
          end else begin
            state_d = ffca_pkg::S_FIT;
          end
        end else if (addr_q == '0) begin
          state_d = ffca_pkg::S_DONE;
        end else begin
          state_d = ffca_pkg::S_LOOK;
        end
      end
      ffca_pkg::S_FIT: begin
        if (fit_hit) begin
          state_d = (rest_w != '0) ? ffca_pkg::S_SLOT : ffca_pkg::S_MV_RD;
        end else if (fit_last) begin
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_MV_RD: begin
        if (mv_up_q) begin
          state_d = (m_q > i_q) ? ffca_pkg::S_MV_WR : ffca_pkg::S_DONE;
        end else if ((m_q + CW'(1)) < cnt_q) begin
          state_d = ffca_pkg::S_MV_WR;
        end else begin
          state_d = (op_q == ffca_pkg::OP_ALLOC) ? ffca_pkg::S_SLOT : ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_MV_WR: state_d = ffca_pkg::S_MV_RD;
      ffca_pkg::S_SLOT: if (!valid_q[s_q]) state_d = ffca_pkg::S_DONE;
      ffca_pkg::S_LOOK: begin
        if (look_hit) begin
          state_d = (cnt_q == '0) ? ffca_pkg::S_MERGE : ffca_pkg::S_WALK;
        end else if (j_q == AIW'(MAX_ALLOCATIONS - 1)) begin
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_WALK: if (!walk_less || walk_last) state_d = ffca_pkg::S_MERGE;
      ffca_pkg::S_MERGE: begin
        if (join_prev && join_next) begin
          state_d = ffca_pkg::S_MV_RD;
        end else if (join_prev || join_next) begin
          state_d = ffca_pkg::S_DONE;
        end else if (cnt_q < CW'(DEPTH)) begin
          state_d = ffca_pkg::S_MV_RD;
        end else begin
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_DONE: if (res_ready_i) state_d = ffca_pkg::S_IDLE;
      default: state_d = ffca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = '0;
    cnt_d = cnt_q; live_d = live_q; total_d = total_q; low_d = low_q; valid_d = valid_q;
    op_d = op_q; req_d = req_q; addr_d = addr_q; need_d = need_q;
    k_d = k_q; m_d = m_q; i_d = i_q; mv_up_d = mv_up_q; j_d = j_q; s_d = s_q;
    seg_d = seg_q; prev_d = prev_q; next_d = next_q;
    has_prev_d = has_prev_q; has_next_d = has_next_q;
    status_d = status_q; payload_d = payload_q;
    case (state_q)
      ffca_pkg::S_INIT: begin
        f_we    = 1'b1;
        f_wdata = '{start: '0, size: INIT_SIZE};
      end
      ffca_pkg::S_IDLE: begin
        op_d = op_i; req_d = req_i; addr_d = addr_i;
      end
      ffca_pkg::S_CHECK: begin
        status_d  = ffca_pkg::ST_OK;
        payload_d = '0;
        need_d    = need_w[SW-1:0];
        k_d = '0; s_d = '0; j_d = '0;
        if (op_q == ffca_pkg::OP_ALLOC) begin
          if (req_q == '0 || need_w > {1'b0, total_q} || cnt_q == '0) begin
            status_d = ffca_pkg::ST_NO_FIT;
          end else if (live_q == LW'(MAX_ALLOCATIONS)) begin
            status_d = ffca_pkg::ST_TABLE_FULL;
          end
        end else if (addr_q == '0) begin
          status_d = ffca_pkg::ST_NULL_FREE;
        end
      end
      ffca_pkg::S_FIT: begin
        if (fit_hit) begin
          seg_d = f_rdata_q;
          if (rest_w != '0) begin
            f_we    = 1'b1;
            f_waddr = k_q[FIW-1:0];
            f_wdata = '{start: f_rdata_q.start + need_q[AW-1:0], size: rest_w};
          end else begin
            m_d     = k_q;
            mv_up_d = 1'b0;
            f_raddr = FIW'(k_q + CW'(1));
          end
        end else if (fit_last) begin
          status_d = ffca_pkg::ST_NO_FIT;
        end else begin
          k_d     = k_q + CW'(1);
          f_raddr = FIW'(k_q + CW'(1));
        end
      end
      ffca_pkg::S_MV_RD: begin
        if (mv_up_q) begin
          if (m_q > i_q) begin
            f_raddr = FIW'(m_q - CW'(1));
          end else begin
            f_we    = 1'b1;
            f_waddr = i_q[FIW-1:0];
            f_wdata = seg_q;
            cnt_d   = cnt_q + CW'(1);
          end
        end else if ((m_q + CW'(1)) < cnt_q) begin
          f_raddr = FIW'(m_q + CW'(1));
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ffca_pkg::S_MV_WR: begin
        f_we    = 1'b1;
        f_waddr = m_q[FIW-1:0];
        f_wdata = f_rdata_q;
        m_d     = mv_up_q ? (m_q - CW'(1)) : (m_q + CW'(1));
      end
      ffca_pkg::S_SLOT: begin
        if (!valid_q[s_q]) begin
          valid_d[s_q] = 1'b1;
          a_we      = 1'b1;
          a_waddr   = s_q;
          a_wdata   = '{start: seg_q.start, size: need_q};
          live_d    = live_q + LW'(1);
          total_d   = tot_sub;
          if (tot_sub < low_q) low_d = tot_sub;
          payload_d = seg_q.start + HDR[AW-1:0];
        end else begin
          s_d = s_q + AIW'(1);
        end
      end
      ffca_pkg::S_LOOK: begin
        if (look_hit) begin
          valid_d[j_q] = 1'b0;
          live_d     = live_q - LW'(1);
          total_d    = total_q + a_rdata_q.size;
          seg_d      = a_rdata_q;
          k_d        = '0;
          i_d        = '0;
          has_prev_d = 1'b0;
          has_next_d = 1'b0;
        end else if (j_q == AIW'(MAX_ALLOCATIONS - 1)) begin
          status_d = ffca_pkg::ST_NOT_ALLOC;
        end else begin
          j_d     = j_q + AIW'(1);
          a_raddr = j_q + AIW'(1);
        end
      end
      ffca_pkg::S_WALK: begin
        if (walk_less) begin
          prev_d     = f_rdata_q;
          has_prev_d = 1'b1;
          if (walk_last) begin
            i_d        = cnt_q;
            has_next_d = 1'b0;
          end else begin
            k_d     = k_q + CW'(1);
            f_raddr = FIW'(k_q + CW'(1));
          end
        end else begin
          i_d        = k_q;
          next_d     = f_rdata_q;
          has_next_d = 1'b1;
        end
      end
      ffca_pkg::S_MERGE: begin
        if (join_prev) begin
          f_we    = 1'b1;
          f_waddr = FIW'(i_q - CW'(1));
          f_wdata = '{start: prev_q.start,
                      size: prev_q.size + seg_q.size + (join_next ? next_q.size : '0)};
          m_d     = i_q;
          mv_up_d = 1'b0;
          f_raddr = FIW'(i_q + CW'(1));
        end else if (join_next) begin
          f_we    = 1'b1;
          f_waddr = i_q[FIW-1:0];
          f_wdata = '{start: seg_q.start, size: seg_q.size + next_q.size};
        end else begin
          m_d     = cnt_q;
          mv_up_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffca_pkg::S_INIT;
      cnt_q   <= CW'(1);
      live_q  <= '0;
      total_q <= INIT_SIZE;
      low_q   <= INIT_SIZE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      live_q  <= live_d;
      total_q <= total_d;
      low_q   <= low_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; req_q <= req_d; addr_q <= addr_d; need_q <= need_d;
    k_q <= k_d; m_q <= m_d; i_q <= i_d; mv_up_q <= mv_up_d; j_q <= j_d; s_q <= s_d;
    seg_q <= seg_d; prev_q <= prev_d; next_q <= next_d;
    has_prev_q <= has_prev_d; has_next_q <= has_next_d;
    status_q <= status_d; payload_q <= payload_d;
  end

  assign in_stall_o  = state_q != ffca_pkg::S_IDLE;
  assign res_valid_o = state_q == ffca_pkg::S_DONE;
  assign res_o       = '{status: status_q, payload: payload_q,
                         free_bytes: total_q, min_free: low_q};

endmodule

`default_nettype wire

@@ src/first_fit_coalescing_allocator.sv @@
// The length of a transaction is set by the walk of the free segment memory (one entry per cycle;
// a shifted entry is read in S_MV_RD and written in S_MV_WR) and the scan of the
// allocation memory for a free slot or a lookup (one entry per cycle).
// One transaction at a time; a finished result waits in the output register.
// Reset: asynchronous; after reset the free table is seeded in S_INIT, then input opens.
// Top level of the first-fit coalescing allocator; depends on ffca_pkg and ffca_engine.
`default_nettype none

module first_fit_coalescing_allocator #(
  parameter int unsigned HEAP_BYTES      = 8388608,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned MAX_ALLOCATIONS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        op_i,
  input  wire logic [23:0]                 request_bytes_i,
  input  wire logic [22:0]                 block_address_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       status_o,
  output logic [22:0]                      payload_address_o,
  output logic [23:0]                      free_bytes_o,
  output logic [23:0]                      min_free_bytes_o
);

  logic           res_valid, res_ready;
  ffca_pkg::res_t res, out_q;
  logic           full_q;

  ffca_engine #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_ALLOCATIONS (MAX_ALLOCATIONS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .req_i       (request_bytes_i),
    .addr_i      (block_address_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !full_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (res_ready) begin
      full_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = full_q;
  assign status_o          = out_q.status;
  assign payload_address_o = out_q.payload;
  assign free_bytes_o      = out_q.free_bytes;
  assign min_free_bytes_o  = out_q.min_free;

endmodule

`default_nettype wire

@@ tb/first_fit_coalescing_allocator_tb.sv @@
// Testbench for the first-fit coalescing allocator: directed table, then random alloc/free traffic.
// Results are checked field by field against a behavioral heap predictor; depends on ffca_pkg.
`default_nettype none

module first_fit_coalescing_allocator_tb;

  localparam int unsigned HEAP = 8388608;
  localparam int unsigned HDR  = 16;
  localparam int unsigned NALLOC = 64;
  localparam int unsigned NSEG = NALLOC + 1;
  localparam int unsigned N_RANDOM = 340;

  typedef struct {
    logic              op;
    logic [23:0]       req;
    logic [22:0]       addr;
    logic              has_exp;
    ffca_pkg::status_e exp_status;
  } stim_t;

  typedef struct {
    ffca_pkg::status_e status;
    logic [22:0]       payload;
    logic [23:0]       free_bytes;
    logic [23:0]       min_free;
  } heap_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = ffca_pkg::OP_ALLOC;
  logic [23:0] request_bytes_i = '0;
  logic [22:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [22:0] payload_address_o;
  logic [23:0] free_bytes_o;
  logic [23:0] min_free_bytes_o;

  first_fit_coalescing_allocator uut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  int unsigned seg_start [NSEG];
  int unsigned seg_size [NSEG];
  int unsigned seg_count;
  int unsigned blk_start [NALLOC];
  int unsigned blk_size [NALLOC];
  bit          blk_live [NALLOC];
  int unsigned heap_free;
  int unsigned heap_low;

  heap_result_t pending_results[$];
  logic [22:0]  live_payloads[$];
  int unsigned  errors = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_sent = 0;
  int unsigned  n_allocs_ok = 0;
  int unsigned  n_frees_ok = 0;
  bit           long_hold = 1'b0;

  function automatic void heap_reset();
    seg_start[0] = 0;
    seg_size[0] = (HEAP - HDR) & ~32'd7;
    seg_count = 1;
    foreach (blk_live[i]) blk_live[i] = 1'b0;
    heap_free = seg_size[0];
    heap_low = seg_size[0];
  endfunction

  function automatic void seg_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k] = seg_size[k+1];
    end
    if (seg_count > 0) seg_count--;
  endfunction

  function automatic void seg_return(int unsigned s, int unsigned sz);
    int unsigned i;
    bit jp, jn;
    i = 0;
    while (i < seg_count && seg_start[i] < s) i++;
    jp = (i > 0) && (seg_start[i-1] + seg_size[i-1] == s);
    jn = (i < seg_count) && (s + sz == seg_start[i]);
    if (jp && jn) begin
      seg_size[i-1] += sz + seg_size[i];
      seg_remove(i);
    end else if (jp) begin
      seg_size[i-1] += sz;
    end else if (jn) begin
      seg_start[i] = s;
      seg_size[i] += sz;
    end else if (seg_count < NSEG) begin
      for (int unsigned k = seg_count; k > i; k--) begin
        seg_start[k] = seg_start[k-1];
        seg_size[k] = seg_size[k-1];
      end
      seg_start[i] = s;
      seg_size[i] = sz;
      seg_count++;
    end
  endfunction

  function automatic heap_result_t heap_apply(logic op, logic [23:0] req, logic [22:0] addr);
    heap_result_t r;
    int unsigned need, slot, i, s, rest;
    r.status = ffca_pkg::ST_OK;
    r.payload = '0;
    if (op == ffca_pkg::OP_ALLOC) begin
      need = (int'(req) + HDR + 7) & ~32'd7;
      slot = NALLOC;
      for (i = 0; i < NALLOC; i++)
        if (!blk_live[i]) begin
          slot = i;
          break;
        end
      if (req == 0 || need > heap_free) begin
        r.status = ffca_pkg::ST_NO_FIT;
      end else if (slot >= NALLOC) begin
        r.status = ffca_pkg::ST_TABLE_FULL;
      end else begin
        for (i = 0; i < seg_count; i++)
          if (seg_size[i] >= need) break;
        if (i >= seg_count) begin
          r.status = ffca_pkg::ST_NO_FIT;
        end else begin
          s = seg_start[i];
          rest = seg_size[i] - need;
          if (rest != 0) begin
            seg_start[i] = s + need;
            seg_size[i] = rest;
          end else begin
            seg_remove(i);
          end
          blk_start[slot] = s;
          blk_size[slot] = need;
          blk_live[slot] = 1'b1;
          heap_free -= need;
          if (heap_free < heap_low) heap_low = heap_free;
          r.payload = 23'(s + HDR);
        end
      end
    end else if (addr == 0) begin
      r.status = ffca_pkg::ST_NULL_FREE;
    end else begin
      slot = NALLOC;
      for (i = 0; i < NALLOC; i++)
        if (blk_live[i] && blk_start[i] + HDR == addr) begin
          slot = i;
          break;
        end
      if (slot >= NALLOC) begin
        r.status = ffca_pkg::ST_NOT_ALLOC;
      end else begin
        blk_live[slot] = 1'b0;
        heap_free += blk_size[slot];
        seg_return(blk_start[slot], blk_size[slot]);
      end
    end
    r.free_bytes = 24'(heap_free);
    r.min_free = 24'(heap_low);
    return r;
  endfunction

  task automatic send_item(logic op, logic [23:0] req, logic [22:0] addr);
    heap_result_t r;
    op_i <= op;
    request_bytes_i <= req;
    block_address_i <= addr;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = heap_apply(op, req, addr);
    pending_results.push_back(r);
    n_sent++;
    if (op == ffca_pkg::OP_ALLOC && r.status == ffca_pkg::ST_OK) begin
      live_payloads.push_back(r.payload);
      n_allocs_ok++;
    end
    if (op == ffca_pkg::OP_FREE && r.status == ffca_pkg::ST_OK) begin
      n_frees_ok++;
      foreach (live_payloads[i])
        if (live_payloads[i] == addr) begin
          live_payloads.delete(i);
          break;
        end
    end
  endtask

  task automatic idle_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_req();
    case ($urandom_range(0, 9))
      0: return 24'($urandom_range(0, 2 ** 24 - 1));
      1: return 24'($urandom_range(1, 8));
      2: return 24'($urandom_range(65536, 1048576));
      default: return 24'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [22:0] rand_free_addr();
    if (live_payloads.size() > 0 && $urandom_range(0, 9) < 8)
      return live_payloads[$urandom_range(0, live_payloads.size() - 1)];
    case ($urandom_range(0, 2))
      0: return '0;
      1: return 23'($urandom);
      default: return 23'($urandom_range(1, 4096) * 8 + HDR);
    endcase
  endfunction

  // receiver stall pattern
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= ~out_stall_i;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (status_o !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status_o);
          errors++;
        end
        if (payload_address_o !== e.payload) begin
          $display("%0t: payload exp %0h got %0h", $time, e.payload, payload_address_o);
          errors++;
        end
        if (free_bytes_o !== e.free_bytes) begin
          $display("%0t: free_bytes exp %0d got %0d", $time, e.free_bytes, free_bytes_o);
          errors++;
        end
        if (min_free_bytes_o !== e.min_free) begin
          $display("%0t: min_free exp %0d got %0d", $time, e.min_free, min_free_bytes_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_t dir[$];
    stim_t t;
    heap_result_t r;
    int unsigned burst;
    heap_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and the null-free, not-allocated, no-fit and ok statuses
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd0, 1'b1, ffca_pkg::ST_NULL_FREE});
    dir.push_back('{ffca_pkg::OP_FREE, 24'hFFFFFF, 23'h7FFFFF, 1'b1, ffca_pkg::ST_NOT_ALLOC});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd0, 23'h7FFFFF, 1'b1, ffca_pkg::ST_NO_FIT});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'hFFFFFF, 23'd0, 1'b1, ffca_pkg::ST_NO_FIT});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd8388608, 23'd0, 1'b1, ffca_pkg::ST_NO_FIT});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd1, 23'd0, 1'b1, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd100, 23'd0, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd8, 23'd0, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd16, 1'b1, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd16, 1'b1, ffca_pkg::ST_NOT_ALLOC});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd56, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd4000000, 23'd0, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd4000000, 23'd0, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_ALLOC, 24'd500000, 23'd0, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd176, 1'b0, ffca_pkg::ST_OK});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd0, 1'b1, ffca_pkg::ST_NULL_FREE});
    dir.push_back('{ffca_pkg::OP_FREE, 24'd0, 23'd16, 1'b1, ffca_pkg::ST_NOT_ALLOC});
    foreach (dir[i]) begin
      t = dir[i];
      send_item(t.op, t.req, t.addr);
      r = pending_results[$];
      if (t.has_exp && r.status != t.exp_status) begin
        $display("%0t: directed row %0d exp %0d predicted %0d", $time, i, t.exp_status,
                 r.status);
        errors++;
      end
    end
    // return everything, then fill the allocation table
    while (live_payloads.size() > 0) send_item(ffca_pkg::OP_FREE, '0, live_payloads[0]);
    for (int i = 0; i < NALLOC + 2; i++)
      send_item(ffca_pkg::OP_ALLOC, 24'($urandom_range(1, 64)), '0);
    while (live_payloads.size() > 0)
      send_item(ffca_pkg::OP_FREE, '0,
                live_payloads[$urandom_range(0, live_payloads.size() - 1)]);

    // pause until drained
    idle_sender(1);
    while (pending_results.size() > 0) @(posedge clk_i);

    // receiver holds off while items keep coming
    long_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item(ffca_pkg::OP_ALLOC, rand_req(), '0);
    join

    for (int n = 0; n < N_RANDOM;) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        if ($urandom_range(0, 99) < 55)
          send_item(ffca_pkg::OP_ALLOC, rand_req(), 23'($urandom));
        else
          send_item(ffca_pkg::OP_FREE, 24'($urandom), rand_free_addr());
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 80));
    end
    idle_sender(1);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d results: %0d allocs and %0d frees succeeded.",
             n_sent, n_checked, n_allocs_ok, n_frees_ok);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ffca_pkg.sv
src/ffca_engine.sv
src/first_fit_coalescing_allocator.sv
tb/first_fit_coalescing_allocator_tb.sv
